// ===== hdl/binary_to_decimal_ascii_core_defines.svh =====
// Assertion macros for the binary to decimal ASCII converter checks.
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bda_pkg.sv =====
// Types, constants and control store of the binary to decimal ASCII converter.
package bda_pkg;

  localparam int unsigned ValueW = 16;
  localparam int unsigned CharW  = 6;
  localparam int unsigned CountW = 4;

  typedef enum logic [1:0] {
    STEP_FETCH = 2'd0,
    STEP_SUB   = 2'd1,
    STEP_EMIT  = 2'd2,
    STEP_UNITS = 2'd3
  } step_t;

  typedef enum logic [1:0] {
    COND_ALWAYS     = 2'd0,
    COND_IN_VALID   = 2'd1,
    COND_GE         = 2'd2,
    COND_LAST_PLACE = 2'd3
  } cond_t;

  typedef struct packed {
    logic  load_in;
    logic  sub_en;
    logic  emit_cnt;
    logic  emit_rest;
    logic  place_inc;
    cond_t cond;
    step_t jump;
    step_t next;
  } ctrl_t;

  // '0' is 6'b110000, so a digit below 16 is just ORed into the low bits.
  localparam logic [1:0] CharHi = 2'b11;

  function automatic logic [ValueW-1:0] place_weight(input logic [1:0] place);
    logic [ValueW-1:0] w;
    case (place)
      2'd0:    w = 16'd10000;
      2'd1:    w = 16'd1000;
      2'd2:    w = 16'd100;
      2'd3:    w = 16'd10;
      default: w = 16'd10;
    endcase
    return w;
  endfunction

  // Control store: taken branch goes to jump, otherwise to next.
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t c;
    c = '0;
    case (step)
      STEP_FETCH: begin
        c.load_in = 1'b1;
        c.cond    = COND_IN_VALID;
        c.jump    = STEP_SUB;
        c.next    = STEP_FETCH;
      end
      STEP_SUB: begin
        c.sub_en = 1'b1;
        c.cond   = COND_GE;
        c.jump   = STEP_SUB;
        c.next   = STEP_EMIT;
      end
      STEP_EMIT: begin
        c.emit_cnt  = 1'b1;
        c.place_inc = 1'b1;
        c.cond      = COND_LAST_PLACE;
        c.jump      = STEP_UNITS;
        c.next      = STEP_SUB;
      end
      STEP_UNITS: begin
        c.emit_rest = 1'b1;
        c.cond      = COND_ALWAYS;
        c.jump      = STEP_FETCH;
        c.next      = STEP_FETCH;
      end
      default: begin
        c.cond = COND_ALWAYS;
        c.jump = STEP_FETCH;
        c.next = STEP_FETCH;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/binary_to_decimal_ascii_core.sv =====
// Unsigned 16-bit binary to decimal ASCII digits, most significant first.
// One value is taken at a time and turned into 1 to 5 digit transfers, leading zeros
// dropped, the units digit always sent and flagged by out_last_digit. A small
// control store sequences one subtractor: each decimal place subtracts its weight once
// per unit of its digit, then a failed compare and the emit step finish the place;
// a fetch step comes before the places and a units step after them. No new value is
// taken until the units digit has been sent to the output register, and the output
// side can hold off any digit. The last digit waits in the output register while the
// next value is taken.
module binary_to_decimal_ascii_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bda_pkg::ValueW-1:0]     in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bda_pkg::CharW-1:0]      out_digit_char,
  output logic                           out_last_digit
);

  bda_pkg::step_t                step_r, step_nxt;
  bda_pkg::ctrl_t                ctrl;
  logic [bda_pkg::ValueW-1:0]    rest_r, rest_nxt;
  logic [bda_pkg::CountW-1:0]    count_r, count_nxt;
  logic [1:0]                    place_r, place_nxt;
  logic                          started_r, started_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [bda_pkg::CharW-1:0]     out_char_r, out_char_nxt;
  logic                          out_last_r, out_last_nxt;
  logic [bda_pkg::ValueW-1:0]    weight;
  logic                          ge;
  logic                          out_free;
  logic                          want_emit;
  logic                          stall;
  logic                          cond_true;

  assign ctrl     = bda_pkg::ucode(step_r);
  assign weight   = bda_pkg::place_weight(place_r);
  assign ge       = (rest_r >= weight);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = ctrl.load_in;

  always_comb begin
    want_emit     = ctrl.emit_rest || (ctrl.emit_cnt && started_r);
    stall         = want_emit && !out_free;
    step_nxt      = step_r;
    rest_nxt      = rest_r;
    count_nxt     = count_r;
    place_nxt     = place_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (ctrl.cond)
      bda_pkg::COND_ALWAYS:     cond_true = 1'b1;
      bda_pkg::COND_IN_VALID:   cond_true = in_valid;
      bda_pkg::COND_GE:         cond_true = ge;
      bda_pkg::COND_LAST_PLACE: cond_true = (place_r == 2'd3);
      default:                  cond_true = 1'b1;
    endcase

    if (!stall) begin
      step_nxt = cond_true ? ctrl.jump : ctrl.next;
      if (ctrl.load_in && in_valid) begin
        rest_nxt    = in_value;
        count_nxt   = '0;
        place_nxt   = '0;
        started_nxt = 1'b0;
      end
      if (ctrl.sub_en && ge) begin
        rest_nxt    = rest_r - weight;
        count_nxt   = bda_pkg::CountW'(count_r + 4'd1);
        started_nxt = 1'b1;
      end
      if (ctrl.place_inc) begin
        place_nxt = 2'(place_r + 2'd1);
        count_nxt = '0;
      end
      if (want_emit) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = ctrl.emit_rest ? {bda_pkg::CharHi, rest_r[bda_pkg::CountW-1:0]}
                                       : {bda_pkg::CharHi, count_r};
        out_last_nxt  = ctrl.emit_rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= bda_pkg::STEP_FETCH;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r     <= rest_nxt;
    count_r    <= count_nxt;
    place_r    <= place_nxt;
    started_r  <= started_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

endmodule

// ===== hdl/bda_checker.sv =====
// Port-level checks for the binary to decimal ASCII converter, bound to the core module.
`include "binary_to_decimal_ascii_core_defines.svh"

module bda_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [bda_pkg::ValueW-1:0] in_value,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [bda_pkg::CharW-1:0]  out_digit_char,
  input logic                       out_last_digit
);

  logic in_xfer;

  assign in_xfer = in_valid && in_ready;

  `BDA_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_value), "waiting value changed")
  `BDA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_digit_char) && $stable(out_last_digit), "stalled digit changed")
  `BDA_ASSERT_NOW(a_char_range, out_valid, out_digit_char >= 6'd48 && out_digit_char <= 6'd57, "digit character out of range")
  `BDA_ASSERT_NEXT(a_busy_after_in, in_xfer, !in_ready, "new value taken while converting")

endmodule

bind binary_to_decimal_ascii_core bda_checker u_bda_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_value       (in_value),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_digit_char (out_digit_char),
  .out_last_digit (out_last_digit)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for binary_to_decimal_ascii_core: random and directed values checked digit by digit.
module tb_top;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 60;
  localparam logic [bda_pkg::CharW-1:0] CharZero = bda_pkg::CharW'(48);

  typedef struct {
    logic [bda_pkg::ValueW-1:0] value;
    bit                         drain_first;
  } num_item_t;

  typedef struct {
    logic [bda_pkg::CharW-1:0] digit_char;
    logic                      last_digit;
  } digit_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [bda_pkg::ValueW-1:0] in_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [bda_pkg::CharW-1:0]  out_digit_char;
  logic                       out_last_digit;

  num_item_t   num_queue[$];
  digit_t      digit_queue[$];
  logic        in_fire_q = 1'b0;
  int unsigned char_count = 0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned rx_cycle = 0;
  bit          hold_done = 1'b0;

  binary_to_decimal_ascii_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_digit_char(out_digit_char),
    .out_last_digit(out_last_digit)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Decimal digits by repeated subtraction, leading zeros dropped.
  task automatic push_decimal_digits(input logic [bda_pkg::ValueW-1:0] value);
    logic [bda_pkg::ValueW-1:0] rest;
    logic [bda_pkg::ValueW-1:0] weights[4];
    logic [3:0]                 count;
    bit                         started;
    digit_t                     d;
    weights = '{16'd10000, 16'd1000, 16'd100, 16'd10};
    rest = value;
    started = 1'b0;
    for (int p = 0; p < 4; p++) begin
      count = '0;
      while (rest >= weights[p]) begin
        rest = rest - weights[p];
        count++;
        started = 1'b1;
      end
      if (started) begin
        d.digit_char = CharZero | bda_pkg::CharW'(count);
        d.last_digit = 1'b0;
        digit_queue.push_back(d);
      end
    end
    d.digit_char = CharZero | bda_pkg::CharW'(rest);
    d.last_digit = 1'b1;
    digit_queue.push_back(d);
  endtask

  // Sender: bursts and gaps, holds payload until the transfer.
  always @(negedge clk) begin
    num_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_value <= '0;
    end else if (in_valid && !in_fire_q) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (num_queue.size() == 0 ||
                 (num_queue[0].drain_first && digit_queue.size() != 0)) begin
      in_valid <= 1'b0;
    end else begin
      it = num_queue.pop_front();
      in_valid <= 1'b1;
      in_value <= it.value;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 20);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
  end

  // Receiver: stall modes, plus one long hold to back up the input.
  always @(negedge clk) begin
    rx_cycle++;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && char_count >= 80) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= rx_cycle[2];
      endcase
    end
  end

  // Monitor and checker.
  always @(posedge clk) begin
    digit_t d;
    if (!rst_n) begin
      in_fire_q <= 1'b0;
    end else begin
      in_fire_q <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        push_decimal_digits(in_value);
      end
      if (out_valid && out_ready) begin
        char_count++;
        if (digit_queue.size() == 0) begin
          $error("unexpected digit transfer: digit_char %0d last_digit %0d",
                 out_digit_char, out_last_digit);
          error_count++;
        end else begin
          d = digit_queue.pop_front();
          if (out_digit_char !== d.digit_char) begin
            $error("digit_char: expected %0d, got %0d", d.digit_char, out_digit_char);
            error_count++;
          end
          if (out_last_digit !== d.last_digit) begin
            $error("last_digit: expected %0d, got %0d", d.last_digit, out_last_digit);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    num_item_t it;
    logic [bda_pkg::ValueW-1:0] directed[$];
    int unsigned sel;
    int unsigned pow;
    directed = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd11, 16'd99, 16'd100, 16'd101,
                 16'd999, 16'd1000, 16'd1001, 16'd9999, 16'd10000, 16'd10001,
                 16'd65535, 16'd65534, 16'd59999, 16'd60000, 16'd12345, 16'd54321,
                 16'h8000, 16'h7fff, 16'h5555, 16'haaaa, 16'd50009};
    foreach (directed[i]) begin
      it.value = directed[i];
      it.drain_first = 1'b0;
      num_queue.push_back(it);
    end
    for (int i = 0; i < 250; i++) begin
      sel = $urandom_range(0, 9);
      pow = 1;
      case (sel)
        0: it.value = bda_pkg::ValueW'($urandom_range(0, 9));
        1: it.value = bda_pkg::ValueW'($urandom_range(10, 99));
        2: it.value = bda_pkg::ValueW'($urandom_range(100, 999));
        3: it.value = bda_pkg::ValueW'($urandom_range(1000, 9999));
        4: begin
          for (int k = $urandom_range(1, 4); k > 0; k--) pow = pow * 10;
          it.value = bda_pkg::ValueW'(pow * $urandom_range(1, 6) - $urandom_range(0, 1));
        end
        default: it.value = bda_pkg::ValueW'($urandom_range(0, 65535));
      endcase
      it.drain_first = (i == 0) || (i == 150);
      num_queue.push_back(it);
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    while (num_queue.size() != 0 || in_valid) @(negedge clk);
    while (digit_queue.size() != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);
    if (error_count == 0 && digit_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
